### design/infix_expression_evaluator_defines.svh
// Assertion macros shared by the checkers of the infix expression evaluator.
// No dependencies; each macro expects signals named clk and arst_n in scope.
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IEE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iee checker: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iee checker: assertion failed");

`endif

### design/iee_pkg.sv
// Shared types, constants and decode functions of the infix expression evaluator.
// No dependencies; the divider, datapath, controller and top level import this package.
package iee_pkg;

	// Stack sizing.
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_W-1:0] word_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [1:0]        act_t;
	typedef logic [1:0]        err_t;

	// Operator codes held on the operator stack.
	localparam op_t OP_SENT = 3'd0;
	localparam op_t OP_ADD  = 3'd1;
	localparam op_t OP_SUB  = 3'd2;
	localparam op_t OP_MUL  = 3'd3;
	localparam op_t OP_DIV  = 3'd4;
	localparam op_t OP_LPAR = 3'd5;

	// Decisions taken against the top of the operator stack.
	localparam act_t ACT_PUSH   = 2'd0;
	localparam act_t ACT_REDUCE = 2'd1;
	localparam act_t ACT_CANCEL = 2'd2;
	localparam act_t ACT_DONE   = 2'd3;

	// Error codes.
	localparam err_t ERR_NONE      = 2'd0;
	localparam err_t ERR_UNDERFLOW = 2'd1;
	localparam err_t ERR_OVERFLOW  = 2'd2;
	localparam err_t ERR_DIV_ZERO  = 2'd3;

	// Characters.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Command bundle from the controller to the datapath.
	typedef struct packed {
		logic load_tok;
		logic push_opnd;
		logic opr_rd;
		logic opr_push;
		logic opr_pop;
		logic latch_op;
		logic rd_top;
		logic rd_second;
		logic latch_b;
		logic latch_a;
		logic alu_load;
		logic div_start;
		logic div_load;
		logic res_write;
		logic emit;
		logic set_err;
		err_t err;
	} dp_cmd_t;

	// Status bundle from the datapath to the controller.
	typedef struct packed {
		logic is_op;
		logic is_end;
		act_t act;
		logic reducible;
		logic opnd_full;
		logic opr_full;
		logic opnd_empty;
		logic op_is_div;
		logic b_zero;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// True for the characters that drive the operator stack.
	function automatic logic is_operator(input logic [7:0] c);
		logic r;
		case (c) inside
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR, CH_END: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Operator code pushed for a character.
	function automatic op_t op_code(input logic [7:0] c);
		op_t r;
		case (c)
			CH_PLUS:  r = OP_ADD;
			CH_MINUS: r = OP_SUB;
			CH_STAR:  r = OP_MUL;
			CH_SLASH: r = OP_DIV;
			default:  r = OP_LPAR;
		endcase
		return r;
	endfunction

	// Precedence decision for an operator character against the top operator.
	function automatic act_t decide(input logic [7:0] c, input op_t t);
		act_t r;
		case (c) inside
			CH_PLUS, CH_MINUS:
				r = (t == OP_SENT || t == OP_LPAR) ? ACT_PUSH : ACT_REDUCE;
			CH_STAR, CH_SLASH:
				r = (t == OP_MUL || t == OP_DIV) ? ACT_REDUCE : ACT_PUSH;
			CH_LPAR:
				r = ACT_PUSH;
			CH_RPAR:
				r = (t == OP_LPAR) ? ACT_CANCEL : ACT_REDUCE;
			default:
				r = (t == OP_SENT) ? ACT_DONE : ACT_REDUCE;
		endcase
		return r;
	endfunction

endpackage

### design/iee_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies beyond its own parameters.
module iee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/iee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating towards zero.
// Depends on iee_pkg for the data width.
module iee_divider
	import iee_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t dividend,
	input  word_t divisor,
	output logic  done,
	output word_t quotient
);

	localparam int STEP_W = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	word_t             quo_q;
	word_t             rem_q;
	word_t             div_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   shifted;

	// Shift in the next dividend bit and try to subtract the divisor.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, div_q};

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DATA_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands are taken as magnitudes; the sign is restored at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			quo_q <= dividend[DATA_W-1] ? (~dividend + word_t'(1)) : dividend;
			div_q <= divisor[DATA_W-1] ? (~divisor + word_t'(1)) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + word_t'(1)) : quo_q;

endmodule

### design/iee_datapath.sv
// Datapath of the infix expression evaluator: both stacks, operand registers,
// arithmetic, error tracking and the output register. Uses iee_pkg, iee_ram, iee_divider.
module iee_datapath
	import iee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] token_char,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic       out_ready,
	output logic       out_valid,
	output word_t      out_value,
	output err_t       out_error
);

	logic [7:0] tok_q;
	op_t        op_q;
	word_t      a_q;
	word_t      b_q;
	word_t      res_q;
	cnt_t       opr_cnt_q;
	cnt_t       opnd_cnt_q;
	err_t       sticky_q;
	logic       out_valid_q;
	word_t      out_value_q;
	err_t       out_error_q;

	cnt_t       opr_cnt_m1;
	cnt_t       opnd_cnt_m1;
	cnt_t       opnd_cnt_m2;
	logic [OP_W-1:0] opr_rdata;
	word_t      opnd_rdata;
	op_t        top_op;
	logic       opnd_we;
	addr_t      opnd_waddr;
	word_t      opnd_wdata;
	word_t      alu_out;
	word_t      div_quo;
	logic       div_done;

	assign opr_cnt_m1  = opr_cnt_q - cnt_t'(1);
	assign opnd_cnt_m1 = opnd_cnt_q - cnt_t'(1);
	assign opnd_cnt_m2 = opnd_cnt_q - cnt_t'(2);

	// Operator stack; the bottom entry is the sentinel and is never stored.
	iee_ram #(
		.WIDTH(OP_W),
		.DEPTH(STACK_DEPTH)
	) u_opr_ram (
		.clk  (clk),
		.we   (cmd.opr_push),
		.waddr(opr_cnt_q[ADDR_W-1:0]),
		.wdata(op_code(tok_q)),
		.re   (cmd.opr_rd),
		.raddr(opr_cnt_m1[ADDR_W-1:0]),
		.rdata(opr_rdata)
	);

	// Operand stack: pushes of digits and write-back of reduction results.
	assign opnd_we    = cmd.push_opnd || cmd.res_write;
	assign opnd_waddr = cmd.res_write ? opnd_cnt_m2[ADDR_W-1:0] : opnd_cnt_q[ADDR_W-1:0];
	assign opnd_wdata = cmd.res_write ? res_q : (word_t'(tok_q) - word_t'(CH_ZERO));

	iee_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_opnd_ram (
		.clk  (clk),
		.we   (opnd_we),
		.waddr(opnd_waddr),
		.wdata(opnd_wdata),
		.re   (cmd.rd_top || cmd.rd_second),
		.raddr(cmd.rd_second ? opnd_cnt_m2[ADDR_W-1:0] : opnd_cnt_m1[ADDR_W-1:0]),
		.rdata(opnd_rdata)
	);

	// Divider for the division operator.
	iee_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(a_q),
		.divisor (b_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Top operator: the sentinel when only the bottom entry is present.
	assign top_op = (opr_cnt_q == cnt_t'(1)) ? OP_SENT : op_t'(opr_rdata);

	// Combinational operators; division by zero yields zero here.
	always_comb begin
		case (op_q)
			OP_ADD:  alu_out = a_q + b_q;
			OP_SUB:  alu_out = a_q - b_q;
			OP_MUL:  alu_out = a_q * b_q;
			default: alu_out = '0;
		endcase
	end

	// Stack counters, error code and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opr_cnt_q   <= cnt_t'(1);
			opnd_cnt_q  <= '0;
			sticky_q    <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.set_err && sticky_q == ERR_NONE) begin
				sticky_q <= cmd.err;
			end
			if (cmd.push_opnd) begin
				opnd_cnt_q <= opnd_cnt_q + cnt_t'(1);
			end
			if (cmd.res_write) begin
				opnd_cnt_q <= opnd_cnt_m1;
			end
			if (cmd.opr_push) begin
				opr_cnt_q <= opr_cnt_q + cnt_t'(1);
			end
			if (cmd.opr_pop) begin
				opr_cnt_q <= opr_cnt_m1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				opr_cnt_q   <= cnt_t'(1);
				opnd_cnt_q  <= '0;
				sticky_q    <= ERR_NONE;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			tok_q <= token_char;
		end
		if (cmd.latch_op) begin
			op_q <= top_op;
		end
		if (cmd.latch_b) begin
			b_q <= opnd_rdata;
		end
		if (cmd.latch_a) begin
			a_q <= opnd_rdata;
		end
		if (cmd.alu_load) begin
			res_q <= alu_out;
		end
		if (cmd.div_load) begin
			res_q <= div_quo;
		end
		if (cmd.emit) begin
			out_value_q <= (opnd_cnt_q == '0) ? '0 : opnd_rdata;
			out_error_q <= sticky_q;
		end
	end

	// Status towards the controller.
	always_comb begin
		stat.is_op      = is_operator(tok_q);
		stat.is_end     = (tok_q == CH_END);
		stat.act        = decide(tok_q, top_op);
		stat.reducible  = (top_op != OP_SENT) && (top_op != OP_LPAR)
			&& (opnd_cnt_q >= cnt_t'(2));
		stat.opnd_full  = (opnd_cnt_q >= cnt_t'(STACK_DEPTH));
		stat.opr_full   = (opr_cnt_q >= cnt_t'(STACK_DEPTH));
		stat.opnd_empty = (opnd_cnt_q == '0);
		stat.op_is_div  = (op_q == OP_DIV);
		stat.b_zero     = (b_q == '0);
		stat.div_done   = div_done;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_error = out_error_q;

endmodule

### design/iee_ctrl.sv
// Controller state machine of the infix expression evaluator.
// Depends on iee_pkg for the command and status bundles.
module iee_ctrl
	import iee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_OPR_RD   = 4'd2;
	localparam logic [3:0] S_DECIDE   = 4'd3;
	localparam logic [3:0] S_RD_B     = 4'd4;
	localparam logic [3:0] S_RD_A     = 4'd5;
	localparam logic [3:0] S_EXEC     = 4'd6;
	localparam logic [3:0] S_DIV      = 4'd7;
	localparam logic [3:0] S_WRITE    = 4'd8;
	localparam logic [3:0] S_FIN_RD   = 4'd9;
	localparam logic [3:0] S_EMIT     = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.err = ERR_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_tok = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_op) begin
					state_d = S_OPR_RD;
				end else begin
					if (stat.opnd_full) begin
						cmd.set_err = 1'b1;
						cmd.err     = ERR_OVERFLOW;
					end else begin
						cmd.push_opnd = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_OPR_RD: begin
				cmd.opr_rd = 1'b1;
				state_d    = S_DECIDE;
			end
			S_DECIDE: begin
				unique case (stat.act)
					ACT_PUSH: begin
						if (stat.opr_full) begin
							cmd.set_err = 1'b1;
							cmd.err     = ERR_OVERFLOW;
						end else begin
							cmd.opr_push = 1'b1;
						end
						state_d = S_IDLE;
					end
					ACT_CANCEL: begin
						cmd.opr_pop = 1'b1;
						state_d     = S_IDLE;
					end
					ACT_DONE: begin
						state_d = S_FIN_RD;
					end
					default: begin
						if (stat.reducible) begin
							cmd.opr_pop  = 1'b1;
							cmd.latch_op = 1'b1;
							cmd.rd_top   = 1'b1;
							state_d      = S_RD_B;
						end else begin
							cmd.set_err = 1'b1;
							cmd.err     = ERR_UNDERFLOW;
							state_d     = stat.is_end ? S_FIN_RD : S_IDLE;
						end
					end
				endcase
			end
			S_RD_B: begin
				cmd.latch_b   = 1'b1;
				cmd.rd_second = 1'b1;
				state_d       = S_RD_A;
			end
			S_RD_A: begin
				cmd.latch_a = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				if (stat.op_is_div && !stat.b_zero) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					// Division by zero takes the zero from the combinational path.
					if (stat.op_is_div) begin
						cmd.set_err = 1'b1;
						cmd.err     = ERR_DIV_ZERO;
					end
					cmd.alu_load = 1'b1;
					state_d      = S_WRITE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_load = 1'b1;
					state_d      = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.res_write = 1'b1;
				state_d       = S_OPR_RD;
			end
			S_FIN_RD: begin
				cmd.rd_top = 1'b1;
				if (stat.opnd_empty) begin
					cmd.set_err = 1'b1;
					cmd.err     = ERR_UNDERFLOW;
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/infix_expression_evaluator.sv
// Infix expression evaluator: one character per item, two stacks held in RAMs,
// an operator-precedence controller and an iterative divider. Each character is
// accepted only while the controller is idle. A digit or other non-operator
// character is pushed as an operand. An operator is checked against the top
// operator and pushed, cancelled or reduced; a reduction reads two operands and
// writes the result back, division using the one-bit-per-cycle divider. After its
// reductions the end marker '#' reads the top operand, waits while the output
// register holds an earlier result not yet taken, and loads the operand there. That
// register can hold a result while new items arrive. Both stacks are 64 entries
// deep and need no clearing after reset. Uses iee_pkg, iee_ctrl and iee_datapath.
module infix_expression_evaluator
	import iee_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         token_char,
	input  logic               in_valid,
	output logic               in_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         error_code,
	output logic               out_valid,
	input  logic               out_ready
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	word_t    out_value;
	err_t     out_error;

	// Sequencing of pushes, reductions and the end-marker result.
	iee_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Stacks, arithmetic and output register.
	iee_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.token_char(token_char),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_value (out_value),
		.out_error (out_error)
	);

	assign result_value = signed'(out_value);
	assign error_code   = out_error;

endmodule

### design/iee_checker.sv
// Port-level checker of the infix expression evaluator, bound to the top level.
// Depends on infix_expression_evaluator_defines.svh for the assertion macros.
`include "infix_expression_evaluator_defines.svh"

module iee_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [31:0] result_value,
	input logic [1:0]         error_code,
	input logic               out_valid,
	input logic               out_ready
);

	// A waiting result keeps its value until it is taken.
	`IEE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({result_value, error_code}))

	// The controller is busy in the cycle after it takes an item.
	`IEE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// No result can appear in the cycle after an item is taken.
	`IEE_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid)

	// Loading a result returns the controller to idle.
	`IEE_ASSERT_SAME(a_idle_on_result, $rose(out_valid), in_ready)

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);

### tb/tb_infix_expression_evaluator.sv
// Self-checking testbench for the infix expression evaluator: directed and random items.
// Depends on iee_pkg and the infix_expression_evaluator top level in the design folder.
// A built-in two-stack predictor supplies the expected result of the untyped end markers.
`timescale 1ns / 1ps

module tb_infix_expression_evaluator
	import iee_pkg::*;
();

	localparam int RANDOM_ITEMS  = 1800;
	localparam int HOLD_CYCLES   = 600;
	localparam int DRAIN_CYCLES  = 100;
	localparam int RUN_LIMIT     = 1000000;
	localparam int DIRECTED_ROWS = 27;

	// Whether a directed row carries its expected result or leaves it to the predictor.
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic [31:0] value;
		err_t        err;
	} outcome_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        typed;
		logic [31:0] value;
		err_t        err;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic [7:0]         token_char;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] result_value;
	logic [1:0]         error_code;
	logic               out_valid;
	logic               out_ready;

	outcome_t    pending_results[$];
	logic [7:0]  expr_chars[$];
	int          failures = 0;
	int          sent_items = 0;
	int          burst_left = 0;
	int          cycle_count = 0;
	bit          hold_request = 1'b0;

	// Predictor state: the two stacks and the first error since the last end marker.
	logic [31:0] operand_mem [STACK_DEPTH];
	op_t         operator_mem [STACK_DEPTH];
	int          operand_depth;
	int          operator_depth;
	err_t        first_error;

	// Directed items: empty stack, field extremes, malformed brackets, division by zero
	// and the most negative value divided by minus one. Unnamed characters are in hex.
	row_t directed_rows [DIRECTED_ROWS] = '{
		{CH_RPAR,  PREDICTED, 32'd0,         ERR_NONE},
		{CH_END,   TYPED,     32'd0,         ERR_UNDERFLOW},
		{8'hFF,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_MINUS, PREDICTED, 32'd0,         ERR_NONE},
		{8'h00,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_END,   TYPED,     32'd255,       ERR_NONE},
		{CH_LPAR,  PREDICTED, 32'd0,         ERR_NONE},
		{8'h39,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_SLASH, PREDICTED, 32'd0,         ERR_NONE},
		{CH_ZERO,  PREDICTED, 32'd0,         ERR_NONE},
		{CH_END,   TYPED,     32'd0,         ERR_DIV_ZERO},
		{8'hB0,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_STAR,  PREDICTED, 32'd0,         ERR_NONE},
		{8'hB0,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_STAR,  PREDICTED, 32'd0,         ERR_NONE},
		{8'hB0,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_STAR,  PREDICTED, 32'd0,         ERR_NONE},
		{8'hB0,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_STAR,  PREDICTED, 32'd0,         ERR_NONE},
		{8'h38,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_SLASH, PREDICTED, 32'd0,         ERR_NONE},
		{CH_LPAR,  PREDICTED, 32'd0,         ERR_NONE},
		{8'h2E,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_PLUS,  PREDICTED, 32'd0,         ERR_NONE},
		{8'h31,    PREDICTED, 32'd0,         ERR_NONE},
		{CH_RPAR,  PREDICTED, 32'd0,         ERR_NONE},
		{CH_END,   TYPED,     32'h80000000,  ERR_NONE}
	};

	infix_expression_evaluator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_char   (token_char),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.result_value (result_value),
		.error_code   (error_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

	// Clock and cycle counter.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// True for the characters that act on the operator stack.
	function automatic bit is_symbol(input logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR, CH_END: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void note_error(input err_t code);
		if (first_error == ERR_NONE) begin
			first_error = code;
		end
	endfunction

	function automatic void clear_stacks();
		operator_mem[0] = OP_SENT;
		operator_depth  = 1;
		operand_depth   = 0;
		first_error     = ERR_NONE;
	endfunction

	function automatic void push_operand(input logic [31:0] v);
		if (operand_depth >= STACK_DEPTH) begin
			note_error(ERR_OVERFLOW);
		end else begin
			operand_mem[operand_depth] = v;
			operand_depth++;
		end
	endfunction

	function automatic void push_operator(input op_t op);
		if (operator_depth >= STACK_DEPTH) begin
			note_error(ERR_OVERFLOW);
		end else begin
			operator_mem[operator_depth] = op;
			operator_depth++;
		end
	endfunction

	// Arithmetic of one reduction; division truncates towards zero.
	function automatic logic [31:0] combine(input op_t op, input logic [31:0] a,
			input logic [31:0] b);
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		logic signed [31:0] q;
		sa = a;
		sb = b;
		case (op)
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_MUL: return a * b;
			default: begin
				if (b == 32'd0) begin
					note_error(ERR_DIV_ZERO);
					return 32'd0;
				end
				if (a == 32'h80000000 && b == 32'hFFFFFFFF) begin
					return 32'h80000000;
				end
				q = sa / sb;
				return q;
			end
		endcase
	endfunction

	// Pops one operator and two operands and pushes the outcome; 0 when not possible.
	function automatic bit fold_top();
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		op = (operator_depth == 0) ? OP_SENT : operator_mem[operator_depth - 1];
		if (op == OP_SENT || op == OP_LPAR || operand_depth < 2) begin
			note_error(ERR_UNDERFLOW);
			return 1'b0;
		end
		operator_depth--;
		b = operand_mem[operand_depth - 1];
		a = operand_mem[operand_depth - 2];
		operand_depth -= 2;
		operand_mem[operand_depth] = combine(op, a, b);
		operand_depth++;
		return 1'b1;
	endfunction

	// Advances the predictor by one character; returns 1 when a result is due.
	function automatic bit evaluate_char(input logic [7:0] c, output logic [31:0] v,
			output err_t e);
		op_t top;
		op_t code;
		bit  busy;
		v = 32'd0;
		e = ERR_NONE;
		if (!is_symbol(c)) begin
			push_operand({24'd0, c} - {24'd0, CH_ZERO});
			return 1'b0;
		end
		code = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
			(c == CH_STAR) ? OP_MUL : (c == CH_SLASH) ? OP_DIV : OP_LPAR;
		busy = 1'b1;
		while (busy) begin
			top = (operator_depth == 0) ? OP_SENT : operator_mem[operator_depth - 1];
			case (c)
				CH_PLUS, CH_MINUS: begin
					if (top == OP_SENT || top == OP_LPAR) begin
						push_operator(code);
						busy = 1'b0;
					end else begin
						busy = fold_top();
					end
				end
				CH_STAR, CH_SLASH: begin
					if (top == OP_MUL || top == OP_DIV) begin
						busy = fold_top();
					end else begin
						push_operator(code);
						busy = 1'b0;
					end
				end
				CH_LPAR: begin
					push_operator(OP_LPAR);
					busy = 1'b0;
				end
				CH_RPAR: begin
					if (top == OP_LPAR) begin
						operator_depth--;
						busy = 1'b0;
					end else begin
						busy = fold_top();
					end
				end
				default: begin
					if (top == OP_SENT) begin
						busy = 1'b0;
					end else begin
						busy = fold_top();
					end
				end
			endcase
		end
		if (c != CH_END) begin
			return 1'b0;
		end
		if (operand_depth == 0) begin
			note_error(ERR_UNDERFLOW);
		end else begin
			v = operand_mem[operand_depth - 1];
		end
		e = first_error;
		clear_stacks();
		return 1'b1;
	endfunction

	// Offers one item, waits for it to be taken, records its expectation, then idles
	// between bursts.
	task automatic send_item(input logic [7:0] c, input logic typed,
			input logic [31:0] typed_value, input err_t typed_err);
		logic [31:0] v;
		err_t        e;
		outcome_t    due;
		token_char <= c;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sent_items++;
		if (evaluate_char(c, v, e)) begin
			due.value = typed ? typed_value : v;
			due.err   = typed ? typed_err : e;
			pending_results.push_back(due);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 30);
		end
	endtask

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 6))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			4: return CH_LPAR;
			5: return CH_RPAR;
			default: return CH_END;
		endcase
	endfunction

	function automatic logic [7:0] pick_arith();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Any character that is pushed as an operand.
	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_symbol(c)) begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_noise();
		if ($urandom_range(0, 1) == 0) begin
			return pick_symbol();
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Well-formed expression text, built recursively with bracketed sub-expressions.
	task automatic add_operand(input int depth);
		if (depth > 0 && $urandom_range(0, 4) == 0) begin
			expr_chars.push_back(CH_LPAR);
			add_expression(depth - 1);
			expr_chars.push_back(CH_RPAR);
		end else if ($urandom_range(0, 9) == 0) begin
			expr_chars.push_back(pick_plain());
		end else begin
			expr_chars.push_back(pick_digit());
		end
	endtask

	task automatic add_expression(input int depth);
		int terms;
		terms = $urandom_range(1, 4);
		add_operand(depth);
		for (int i = 1; i < terms; i++) begin
			expr_chars.push_back(pick_arith());
			add_operand(depth);
		end
	endtask

	// One random sequence, mostly well formed, always closed by an end marker.
	task automatic build_sequence();
		int kind;
		int n;
		int pos;
		expr_chars.delete();
		kind = $urandom_range(0, 99);
		if (kind < 82) begin
			add_expression(3);
			if (kind >= 70) begin
				pos = $urandom_range(0, expr_chars.size() - 1);
				case ($urandom_range(0, 2))
					0: expr_chars.insert(pos, pick_noise());
					1: if (expr_chars.size() > 1) expr_chars.delete(pos);
					default: expr_chars[pos] = pick_noise();
				endcase
			end
		end else if (kind < 96) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				expr_chars.push_back(($urandom_range(0, 2) == 0) ? pick_digit() : pick_noise());
			end
		end else if (kind < 98) begin
			// Runs of operands around the operand stack depth.
			n = $urandom_range(58, 70);
			for (int i = 0; i < n; i++) begin
				expr_chars.push_back(pick_digit());
			end
		end else begin
			// Bracket nesting around the operator stack depth.
			n = $urandom_range(58, 68);
			for (int i = 0; i < n; i++) begin
				expr_chars.push_back(CH_LPAR);
			end
			expr_chars.push_back(pick_digit());
			for (int i = 0; i < n; i++) begin
				expr_chars.push_back(CH_RPAR);
			end
		end
		expr_chars.push_back(CH_END);
	endtask

	// Sender: reset, directed items, then random sequences with pressure phases.
	initial begin : stimulus
		bit held;
		bit paused;
		held   = 1'b0;
		paused = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		token_char <= 8'd0;
		clear_stacks();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_item(directed_rows[i].ch, directed_rows[i].typed,
				directed_rows[i].value, directed_rows[i].err);
		end

		while (sent_items < RANDOM_ITEMS + DIRECTED_ROWS) begin
			// Long receiver stall while items keep coming, so the block backs up.
			if (!held && sent_items > 600) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			// Sender stands still until every outstanding result has been taken.
			if (!paused && sent_items > 1200) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				do begin
					@(posedge clk);
				end while (pending_results.size() != 0);
			end
			build_sequence();
			foreach (expr_chars[i]) begin
				send_item(expr_chars[i], PREDICTED, 32'd0, ERR_NONE);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Receiver: stretches of steady, random and sparse readiness, plus one long hold.
	initial begin : receiver
		int span;
		int mode;
		int waited;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				waited = 0;
				while (waited < HOLD_CYCLES) begin
					@(posedge clk);
					waited++;
				end
				hold_request = 1'b0;
			end else begin
				span = $urandom_range(1, 40);
				mode = $urandom_range(0, 2);
				for (int k = 0; k < span && !hold_request; k++) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result_value: expected nothing, got %0d", result_value);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.value) begin
					$error("result_value: expected %0d, got %0d", $signed(want.value),
						result_value);
					failures++;
				end
				if (error_code !== want.err) begin
					$error("error_code: expected %0d, got %0d", want.err, error_code);
					failures++;
				end
			end
		end
	end

	// Timeout.
	initial begin : watchdog
		wait (cycle_count >= RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/iee_pkg.sv
design/iee_ram.sv
design/iee_divider.sv
design/iee_datapath.sv
design/iee_ctrl.sv
design/infix_expression_evaluator.sv
design/iee_checker.sv
tb/tb_infix_expression_evaluator.sv
